// ----- hdl/multi_asset_euler_path_step_macros.svh -----
// assertion macros shared by the euler path step rtl
`ifndef MULTI_ASSET_EULER_PATH_STEP_MACROS_SVH
`define MULTI_ASSET_EULER_PATH_STEP_MACROS_SVH

// same-cycle implication
`define MAEP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MAEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/maep_pkg.sv -----
// shared types and constants of the euler path step block
`default_nettype none

package maep_pkg;

   localparam int DEFAULT_ASSETS = 4;
   localparam int NOISE_FIELDS   = 4;
   localparam int PRICE_FIELDS   = 4;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [1:0] ACT_FACTOR = 2'd0;
   localparam logic [1:0] ACT_RATE   = 2'd1;
   localparam logic [1:0] ACT_PRICE  = 2'd2;
   localparam logic [1:0] ACT_STEP   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_STEP_TIME = 1'd1;

   typedef struct packed {
      logic mac_en;
      logic mac_first;
      logic mul_en;
      logic z_en;
      logic g_en;
      logic commit;
   } lane_ctrl_type;

   typedef struct packed {
      logic               factor_we;
      logic               rate_we;
      logic               price_we;
      logic [1:0]         col;
      logic signed [31:0] value;
   } lane_load_type;

   typedef struct packed {
      logic signed [31:0] price;
      logic               ovf;
   } lane_stat_type;

endpackage

`default_nettype wire

// ----- hdl/maep_lane.sv -----
// one asset lane: factor row mac, drift and diffusion, price update
`default_nettype none

module maep_lane #(
   parameter int ASSETS = maep_pkg::DEFAULT_ASSETS,
   parameter int LANE   = 0,
   parameter int JW     = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire maep_pkg::lane_ctrl_type ctrl,
   input  wire maep_pkg::lane_load_type load,
   input  wire logic [JW-1:0]         col_sel,
   input  wire logic signed [15:0]    noise,
   input  wire logic [15:0]           step_time,
   input  wire logic [15:0]           root_step_time,
   output maep_pkg::lane_stat_type    stat
);
   import maep_pkg::*;

   localparam int AccW   = 48 + $clog2(ASSETS + 1);
   localparam int Acc16W = AccW - 11;
   localparam int PbW    = Acc16W + 17;
   localparam int ZW     = PbW + 1;

   logic signed [31:0]       factor_ff [ASSETS];
   logic signed [31:0]       rate_ff;
   logic signed [31:0]       price_ff;
   logic signed [AccW-1:0]   acc_ff, acc_in;
   logic signed [48:0]       pa_ff, pa_in;
   logic signed [PbW-1:0]    pb_ff, pb_in;
   logic signed [31:0]       z_ff, z_in;
   logic                     zovf_ff, zovf_in;
   logic signed [63:0]       g_ff, g_in;

   logic signed [47:0]       prod;
   logic signed [AccW:0]     acc_rnd;
   logic signed [Acc16W-1:0] acc16;
   logic signed [16:0]       dt_s, sdt_s;
   logic signed [ZW-1:0]     zsum;
   logic signed [ZW-17:0]    zsh;
   logic                     z_fits;
   logic signed [64:0]       grnd;
   logic signed [48:0]       growth;
   logic signed [49:0]       psum;
   logic                     p_fits;
   logic signed [31:0]       p_next;
   logic [JW-1:0]            load_col;

   assign load_col = JW'(load.col);

   // factor row mac
   assign prod   = factor_ff[col_sel] * noise;
   assign acc_in = (ctrl.mac_first ? AccW'(0) : acc_ff)
                 + ((int'(col_sel) <= LANE) ? AccW'(prod) : AccW'(0));

   // drift and diffusion products
   assign acc_rnd = (AccW+1)'(acc_ff) + (AccW+1)'(2048);
   assign acc16   = acc_rnd[AccW:12];
   assign dt_s    = {1'b0, step_time};
   assign sdt_s   = {1'b0, root_step_time};
   assign pa_in   = rate_ff * dt_s;
   assign pb_in   = acc16 * sdt_s;

   // round and clamp z
   assign zsum   = ZW'(pa_ff) + ZW'(pb_ff) + ZW'(32768);
   assign zsh    = zsum[ZW-1:16];
   assign z_fits = (&zsh[ZW-17:31]) | ~(|zsh[ZW-17:31]);
   assign z_in   = z_fits ? zsh[31:0] : (zsh[ZW-17] ? 32'sh80000000 : 32'sh7FFFFFFF);
   assign zovf_in = ~z_fits;

   assign g_in = price_ff * z_ff;

   // price update
   assign grnd   = 65'(g_ff) + 65'(32768);
   assign growth = grnd[64:16];
   assign psum   = 50'(price_ff) + 50'(growth);
   assign p_fits = (&psum[49:31]) | ~(|psum[49:31]);
   assign p_next = p_fits ? psum[31:0] : (psum[49] ? 32'sh80000000 : 32'sh7FFFFFFF);

   assign stat.price = p_next;
   assign stat.ovf   = zovf_ff | ~p_fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ASSETS; k++) begin
            factor_ff[k] <= '0;
         end
         rate_ff  <= '0;
         price_ff <= '0;
      end else begin
         if (load.factor_we) begin
            factor_ff[load_col] <= load.value;
         end
         if (load.rate_we) begin
            rate_ff <= load.value;
         end
         if (load.price_we) begin
            price_ff <= load.value;
         end else if (ctrl.commit) begin
            price_ff <= p_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mac_en) begin
         acc_ff <= acc_in;
      end
      if (ctrl.mul_en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ctrl.z_en) begin
         z_ff    <= z_in;
         zovf_ff <= zovf_in;
      end
      if (ctrl.g_en) begin
         g_ff <= g_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/maep_merge.sv -----
// merges lane results into the registered result word
`default_nettype none

module maep_merge #(
   parameter int ASSETS = maep_pkg::DEFAULT_ASSETS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    commit,
   input  wire maep_pkg::lane_stat_type lane_stat [ASSETS],
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_price_0,
   output logic signed [31:0]           rsp_price_1,
   output logic signed [31:0]           rsp_price_2,
   output logic signed [31:0]           rsp_price_3,
   output logic                         rsp_overflow,
   output logic                         slot_free
);
   import maep_pkg::*;

   logic               valid_ff;
   logic signed [31:0] price_ff [PRICE_FIELDS];
   logic signed [31:0] price_in [PRICE_FIELDS];
   logic               ovf_ff, ovf_in;

   always_comb begin
      ovf_in = 1'b0;
      for (int k = 0; k < ASSETS; k++) begin
         ovf_in = ovf_in | lane_stat[k].ovf;
      end
   end

   for (genvar k = 0; k < PRICE_FIELDS; k++) begin : g_price
      if (k < ASSETS) begin : g_lane
         assign price_in[k] = lane_stat[k].price;
      end else begin : g_none
         assign price_in[k] = '0;
      end
   end

   assign slot_free = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (commit) begin
         valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         for (int k = 0; k < PRICE_FIELDS; k++) begin
            price_ff[k] <= price_in[k];
         end
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_price_0  = price_ff[0];
   assign rsp_price_1  = price_ff[1];
   assign rsp_price_2  = price_ff[2];
   assign rsp_price_3  = price_ff[3];
   assign rsp_overflow = ovf_ff;

endmodule

`default_nettype wire

// ----- hdl/multi_asset_euler_path_step.sv -----
// One Euler-Maruyama step of correlated multi-asset geometric Brownian motion.
// Load words (factor entry, rate, start price) are taken while the input is
// not stalled and produce no result. A step word runs all ASSETS lanes side by
// side: each lane walks its factor row one column per cycle through its own
// 32x16 multiplier, then forms the drift and diffusion products, rounds and
// clamps z, forms the price product, and updates the price and loads the
// result register. After a step word is taken the input stalls until the step
// has updated the prices, and stays stalled while the result register is still
// full. Results are Q16.16 prices with a sticky-per-step overflow flag.
`default_nettype none
`include "multi_asset_euler_path_step_macros.svh"

module multi_asset_euler_path_step #(
   parameter int ASSETS = maep_pkg::DEFAULT_ASSETS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [maep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [maep_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_action,
   input  wire logic [1:0]                         req_row,
   input  wire logic [1:0]                         req_col,
   input  wire logic signed [31:0]                 req_value,
   input  wire logic signed [15:0]                 req_noise_0,
   input  wire logic signed [15:0]                 req_noise_1,
   input  wire logic signed [15:0]                 req_noise_2,
   input  wire logic signed [15:0]                 req_noise_3,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [31:0]                      rsp_price_0,
   output logic signed [31:0]                      rsp_price_1,
   output logic signed [31:0]                      rsp_price_2,
   output logic signed [31:0]                      rsp_price_3,
   output logic                                    rsp_overflow
);
   import maep_pkg::*;

   localparam int JW = (ASSETS > 1) ? $clog2(ASSETS) : 1;
   localparam logic [JW-1:0] LAST_COL = JW'(ASSETS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ZRND = 3'd3;
   localparam logic [2:0] ST_GROW = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [JW-1:0]      col_ff, col_in;
   logic [15:0]        step_time_ff;
   logic [15:0]        root_step_time_ff;
   logic signed [15:0] noise_ff [ASSETS];
   logic signed [15:0] req_noise [NOISE_FIELDS];
   logic               req_accept;
   logic               step_accept;
   logic               slot_free;
   lane_ctrl_type      ctrl;
   lane_load_type      load [ASSETS];
   lane_stat_type      lane_stat [ASSETS];

   assign req_noise[0] = req_noise_0;
   assign req_noise[1] = req_noise_1;
   assign req_noise[2] = req_noise_2;
   assign req_noise[3] = req_noise_3;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid & ~req_stall;
   assign step_accept = req_accept & (req_action == ACT_STEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff      <= '0;
         root_step_time_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_TIME:      step_time_ff      <= csr_data;
            CSR_ROOT_STEP_TIME: root_step_time_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            col_in = '0;
            if (step_accept) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            col_in = col_ff + JW'(1);
            if (col_ff == LAST_COL) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ZRND;
         ST_ZRND: state_in = ST_GROW;
         ST_GROW: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

   assign ctrl.mac_en    = (state_ff == ST_MAC);
   assign ctrl.mac_first = (col_ff == '0);
   assign ctrl.mul_en    = (state_ff == ST_MUL);
   assign ctrl.z_en      = (state_ff == ST_ZRND);
   assign ctrl.g_en      = (state_ff == ST_GROW);
   assign ctrl.commit    = (state_ff == ST_DONE) & slot_free;

   for (genvar k = 0; k < ASSETS; k++) begin : g_lane
      logic hit;

      if (k < NOISE_FIELDS) begin : g_noise
         always_ff @(posedge clock) begin
            if (step_accept) begin
               noise_ff[k] <= req_noise[k];
            end
         end
      end else begin : g_quiet
         always_ff @(posedge clock) begin
            if (step_accept) begin
               noise_ff[k] <= '0;
            end
         end
      end

      assign hit = req_accept & (int'(req_row) == k);
      assign load[k].factor_we = hit & (req_action == ACT_FACTOR) & (req_col <= req_row);
      assign load[k].rate_we   = hit & (req_action == ACT_RATE);
      assign load[k].price_we  = hit & (req_action == ACT_PRICE);
      assign load[k].col       = req_col;
      assign load[k].value     = req_value;

      maep_lane #(
         .ASSETS (ASSETS),
         .LANE   (k),
         .JW     (JW)
      ) u_lane (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .load           (load[k]),
         .col_sel        (col_ff),
         .noise          (noise_ff[col_ff]),
         .step_time      (step_time_ff),
         .root_step_time (root_step_time_ff),
         .stat           (lane_stat[k])
      );
   end

   maep_merge #(
      .ASSETS (ASSETS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .commit       (ctrl.commit),
      .lane_stat    (lane_stat),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_price_0  (rsp_price_0),
      .rsp_price_1  (rsp_price_1),
      .rsp_price_2  (rsp_price_2),
      .rsp_price_3  (rsp_price_3),
      .rsp_overflow (rsp_overflow),
      .slot_free    (slot_free)
   );

   `MAEP_ASSERT_NEXT(a_step_starts_mac, clock, reset, step_accept, state_ff == ST_MAC, "step word did not start the mac")
   `MAEP_ASSERT_NEXT(a_mac_ends, clock, reset, (state_ff == ST_MAC) && (col_ff == LAST_COL), state_ff == ST_MUL, "mac did not end after last column")
   `MAEP_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid), $past(state_ff) == ST_DONE, "result word without a finished step")
   `MAEP_ASSERT_SAME(a_no_overwrite, clock, reset, ctrl.commit, !(rsp_valid && rsp_stall), "result word overwritten while stalled")

endmodule

`default_nettype wire

// ----- dv/multi_asset_euler_path_step_test.sv -----
// self-checking testbench for the multi-asset euler path step block
`default_nettype none

module multi_asset_euler_path_step_test;
   timeunit 1ns;
   timeprecision 1ps;

   import maep_pkg::*;

   localparam int     SETTLE_CYCLES = 20;
   localparam int     CYCLE_LIMIT   = 800000;
   localparam int     WORD_TARGET   = 1070;
   localparam int     HOLD_CYCLES   = 400;
   localparam longint S32_HI        = 64'sd2147483647;
   localparam longint S32_LO        = -64'sd2147483648;

   typedef struct packed {
      logic [3:0][31:0] price;
      logic             ovf;
   } price_set_type;

   class euler_step_book;
      bit [31:0]     chol [16];
      bit [31:0]     drift [4];
      bit [31:0]     spot [4];
      bit [15:0]     dt_q;
      bit [15:0]     root_dt_q;
      price_set_type due_prices [$];
      int            faults;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] d);
         if (idx == CSR_STEP_TIME) begin
            dt_q = d;
         end else if (idx == CSR_ROOT_STEP_TIME) begin
            root_dt_q = d;
         end
      endfunction

      function longint clamp32(longint x, inout bit flag);
         if (x > S32_HI) begin
            flag = 1;
            return S32_HI;
         end
         if (x < S32_LO) begin
            flag = 1;
            return S32_LO;
         end
         return x;
      endfunction

      function void take_word(logic [1:0] act, logic [1:0] r, logic [1:0] c,
                              logic [31:0] v, logic [3:0][15:0] nz);
         price_set_type want;
         longint        acc, z, p, g;
         bit            ovf;
         int            i, j;
         if (act != ACT_STEP) begin
            case (act)
               ACT_FACTOR: begin
                  if (c <= r) chol[r*4+c] = v;
               end
               ACT_RATE: begin
                  drift[r] = v;
               end
               default: begin
                  spot[r] = v;
               end
            endcase
            return;
         end
         ovf = 0;
         for (i = 0; i < 4; i++) begin
            acc = 0;
            for (j = 0; j <= i; j++)
               acc += longint'(signed'(chol[i*4+j])) * longint'(signed'(nz[j]));
            acc = (acc + 64'sd2048) >>> 12;
            z = longint'(signed'(drift[i])) * longint'(dt_q) + acc * longint'(root_dt_q);
            z = clamp32((z + 64'sd32768) >>> 16, ovf);
            p = longint'(signed'(spot[i]));
            g = (p * z + 64'sd32768) >>> 16;
            want.price[i] = 32'(clamp32(p + g, ovf));
         end
         for (i = 0; i < 4; i++)
            spot[i] = want.price[i];
         want.ovf = ovf;
         due_prices.push_back(want);
      endfunction

      function void note_fault(string what, logic [31:0] want, logic [31:0] got);
         faults++;
         if (faults <= 10)
            $display("%0t: %s mismatch: expected %h got %h", $time, what, want, got);
      endfunction

      function void match_prices(price_set_type got);
         price_set_type want;
         int            i;
         if (due_prices.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: result word with nothing expected: %h", $time, got);
            return;
         end
         want = due_prices.pop_front();
         for (i = 0; i < 4; i++)
            if (got.price[i] !== want.price[i])
               note_fault($sformatf("price_%0d", i), want.price[i], got.price[i]);
         if (got.ovf !== want.ovf)
            note_fault("overflow", 32'(want.ovf), 32'(got.ovf));
      endfunction

      function int pending();
         return due_prices.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_action;
   logic [1:0]            req_row;
   logic [1:0]            req_col;
   logic signed [31:0]    req_value;
   logic signed [15:0]    req_noise_0;
   logic signed [15:0]    req_noise_1;
   logic signed [15:0]    req_noise_2;
   logic signed [15:0]    req_noise_3;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [31:0]    rsp_price_0;
   logic signed [31:0]    rsp_price_1;
   logic signed [31:0]    rsp_price_2;
   logic signed [31:0]    rsp_price_3;
   logic                  rsp_overflow;

   euler_step_book book;
   int             words_sent;
   int             cycles;
   bit             calm;
   bit             hold_req;

   multi_asset_euler_path_step uut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_value    (req_value),
      .req_noise_0  (req_noise_0),
      .req_noise_1  (req_noise_1),
      .req_noise_2  (req_noise_2),
      .req_noise_3  (req_noise_3),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_price_0  (rsp_price_0),
      .rsp_price_1  (rsp_price_1),
      .rsp_price_2  (rsp_price_2),
      .rsp_price_3  (rsp_price_3),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("[multi_asset_euler_path_step] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            book.set_reg(csr_index, csr_data);
         if (req_valid && !req_stall)
            book.take_word(req_action, req_row, req_col, req_value,
                           {req_noise_3, req_noise_2, req_noise_1, req_noise_0});
         if (rsp_valid && !rsp_stall)
            book.match_prices(price_set_type'({{rsp_price_3, rsp_price_2, rsp_price_1,
                                                rsp_price_0}, rsp_overflow}));
      end
   end

   // receiver: random stall runs, plus one long hold-off on request
   initial begin
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end else if (calm || $urandom_range(0, 99) < 65) begin
            rsp_stall = 0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_stall = 1;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(20, 60)) @(negedge clock);
            else
               repeat ($urandom_range(1, 3)) @(negedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] draw_fix(int span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [31:0] draw_price();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(1, 32'd33554432);
   endfunction

   function automatic logic [3:0][15:0] draw_noise(bit wide);
      logic [3:0][15:0] nz;
      int               i;
      for (i = 0; i < 4; i++)
         nz[i] = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 32768)) - 16384);
      return nz;
   endfunction

   // called and left at a falling edge
   task automatic push_word(input logic [1:0] act, input logic [1:0] r, input logic [1:0] c,
                            input logic [31:0] v, input logic [3:0][15:0] nz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_action  = act;
      req_row     = r;
      req_col     = c;
      req_value   = v;
      req_noise_0 = nz[0];
      req_noise_1 = nz[1];
      req_noise_2 = nz[2];
      req_noise_3 = nz[3];
      req_valid   = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic push_step(input logic [3:0][15:0] nz);
      push_word(ACT_STEP, 2'($urandom), 2'($urandom), $urandom, nz);
   endtask

   task automatic wait_idle();
      req_valid = 0;
      while (book.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] d);
      csr_index = idx;
      csr_data  = d;
      csr_we    = 1;
      @(negedge clock);
      csr_we    = 0;
   endtask

   task automatic run_episode();
      int kind, r, c;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         for (r = 0; r < 4; r++) begin
            for (c = 0; c <= r; c++)
               push_word(ACT_FACTOR, 2'(r), 2'(c), draw_fix(65536), draw_noise(1));
            if (r < 3 && $urandom_range(0, 9) < 3)
               push_word(ACT_FACTOR, 2'(r), 2'($urandom_range(r + 1, 3)), $urandom,
                         draw_noise(1));
         end
         for (r = 0; r < 4; r++)
            push_word(ACT_RATE, 2'(r), 2'($urandom), draw_fix(32768), draw_noise(1));
         for (r = 0; r < 4; r++)
            push_word(ACT_PRICE, 2'(r), 2'($urandom), draw_price(), draw_noise(1));
      end else if (kind < 9) begin
         repeat ($urandom_range(1, 4))
            push_word(2'($urandom_range(0, 2)), 2'($urandom), 2'($urandom),
                      draw_fix(65536), draw_noise(1));
      end else begin
         repeat (6)
            push_word(2'($urandom), 2'($urandom), 2'($urandom), $urandom, draw_noise(1));
      end
      repeat ($urandom_range(2, 12))
         push_step(draw_noise($urandom_range(0, 9) == 0));
   endtask

   initial begin
      logic [15:0] dt_pick, root_pick;
      int          k;
      book        = new();
      reset       = 1;
      csr_we      = 0;
      csr_index   = '0;
      csr_data    = '0;
      req_valid   = 0;
      req_action  = ACT_FACTOR;
      req_row     = '0;
      req_col     = '0;
      req_value   = '0;
      req_noise_0 = '0;
      req_noise_1 = '0;
      req_noise_2 = '0;
      req_noise_3 = '0;
      words_sent  = 0;
      calm        = 0;
      hold_req    = 0;
      repeat (6) @(negedge clock);
      reset = 0;

      // all-zero state and registers straight out of reset
      push_step('0);
      wait_idle();
      write_reg(CSR_STEP_TIME, 16'hFFFF);
      write_reg(CSR_ROOT_STEP_TIME, 16'hFFFF);
      push_word(ACT_FACTOR, 2'd0, 2'd0, 32'h0001_0000, '0);
      // upper entries must be dropped
      push_word(ACT_FACTOR, 2'd0, 2'd1, 32'h7FFF_FFFF, '0);
      push_word(ACT_FACTOR, 2'd2, 2'd3, 32'h8000_0000, '0);
      push_word(ACT_FACTOR, 2'd3, 2'd3, 32'h8000_0000, '0);
      push_word(ACT_FACTOR, 2'd3, 2'd0, 32'h7FFF_FFFF, '0);
      push_word(ACT_FACTOR, 2'd1, 2'd0, 32'hFFFF_0000, '0);
      push_word(ACT_FACTOR, 2'd1, 2'd1, 32'h0001_0000, '0);
      push_word(ACT_FACTOR, 2'd2, 2'd2, 32'h0000_8000, '0);
      push_word(ACT_RATE, 2'd0, 2'd0, 32'h7FFF_FFFF, '0);
      push_word(ACT_RATE, 2'd1, 2'd0, 32'h8000_0000, '0);
      push_word(ACT_RATE, 2'd3, 2'd0, 32'h0001_0000, '0);
      push_word(ACT_PRICE, 2'd0, 2'd0, 32'h7FFF_FFFF, '0);
      push_word(ACT_PRICE, 2'd1, 2'd0, 32'h8000_0000, '0);
      push_word(ACT_PRICE, 2'd2, 2'd0, 32'h0001_0000, '0);
      push_word(ACT_PRICE, 2'd3, 2'd0, 32'h0064_0000, '0);
      push_step({16'h1000, 16'h0000, 16'h8000, 16'h7FFF});
      push_step({16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000});
      push_word(ACT_PRICE, 2'd2, 2'd0, 32'h0000_0000, '0);
      push_step('0);
      push_step({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});

      k = 0;
      while (words_sent < WORD_TARGET) begin
         wait_idle();
         case (k % 6)
            0: begin
               dt_pick   = 16'h0000;
               root_pick = 16'h0000;
            end
            1: begin
               dt_pick   = 16'hFFFF;
               root_pick = 16'hFFFF;
            end
            2, 4: begin
               root_pick = 16'($urandom);
               dt_pick   = 16'((32'(root_pick) * 32'(root_pick)) >> 16);
            end
            3: begin
               dt_pick   = 16'($urandom);
               root_pick = 16'($urandom);
            end
            default: begin
               dt_pick   = 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
               root_pick = ~dt_pick;
            end
         endcase
         write_reg(CSR_STEP_TIME, dt_pick);
         write_reg(CSR_ROOT_STEP_TIME, root_pick);
         calm = (k % 5 == 2);
         if (k == 4) begin
            // long receiver hold-off while steps keep coming
            hold_req = 1;
            repeat (40) push_step(draw_noise(0));
         end
         repeat ($urandom_range(2, 5)) run_episode();
         k++;
      end

      wait_idle();
      if (book.faults == 0 && book.pending() == 0)
         $display("[multi_asset_euler_path_step] OK");
      else
         $display("[multi_asset_euler_path_step] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
